// ===== rtl/core/lmr_pkg.sv =====
`default_nettype none

package lmr_pkg;

	// Field widths
	localparam int ANGLE_W = 8;
	localparam int COORD_W = 6;
	localparam int INDEX_W = 12;
	localparam int SLOPE_W = 6;
	localparam int ERR_W   = 8;

	// Stream payload widths
	localparam int S_DATA_W = 8;
	localparam int M_DATA_W = 2 * COORD_W + INDEX_W;

	// Configuration port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam logic [0:0] REG_MASK_SIDE = 1'b0;

	localparam logic [COORD_W-1:0] MASK_SIDE_RESET = 6'd15;
	localparam int                 MAX_SIDE_DEFAULT = 63;

	// Angle decoding
	localparam logic [ANGLE_W-1:0] WRAP_DEG    = 8'd180;
	localparam logic [ANGLE_W-1:0] DEG_PER_OCT = 8'd45;
	localparam logic [ANGLE_W-1:0] OCT1_BASE   = 8'd45;
	localparam logic [ANGLE_W-1:0] OCT2_BASE   = 8'd90;
	localparam logic [ANGLE_W-1:0] OCT3_BASE   = 8'd135;

	// Bresenham constants
	localparam logic signed [ERR_W-1:0] ERR_START = -8'sd45;
	localparam logic signed [ERR_W-1:0] ERR_CORR  = 8'sd90;

	typedef enum logic [1:0] {
		OCT_SHALLOW_UP   = 2'd0,
		OCT_STEEP_UP     = 2'd1,
		OCT_STEEP_DOWN   = 2'd2,
		OCT_SHALLOW_DOWN = 2'd3
	} octant_t;

	typedef struct packed {
		octant_t              octant;
		logic [SLOPE_W-1:0]   slope;
	} job_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} q_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/lmr_front.sv =====
`default_nettype none

module lmr_front (
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [lmr_pkg::S_DATA_W-1:0]  s_tdata,   // [7:0] angle_deg
	input  wire logic                          q_full,
	output logic                               push,
	output lmr_pkg::job_t                      job
);

	logic [lmr_pkg::ANGLE_W-1:0] angle;
	logic [lmr_pkg::ANGLE_W-1:0] base;
	logic [lmr_pkg::ANGLE_W-1:0] rem;
	lmr_pkg::octant_t            oct;

	// Take an item whenever the queue has room
	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready;

	// Wrap the angle once, then split it into octant and remainder
	always_comb begin
		angle = (s_tdata >= lmr_pkg::WRAP_DEG) ? s_tdata - lmr_pkg::WRAP_DEG : s_tdata;
		if (angle >= lmr_pkg::OCT3_BASE) begin
			oct  = lmr_pkg::OCT_SHALLOW_DOWN;
			base = lmr_pkg::OCT3_BASE;
		end else if (angle >= lmr_pkg::OCT2_BASE) begin
			oct  = lmr_pkg::OCT_STEEP_DOWN;
			base = lmr_pkg::OCT2_BASE;
		end else if (angle >= lmr_pkg::OCT1_BASE) begin
			oct  = lmr_pkg::OCT_STEEP_UP;
			base = lmr_pkg::OCT1_BASE;
		end else begin
			oct  = lmr_pkg::OCT_SHALLOW_UP;
			base = '0;
		end
		rem = angle - base;
		job.octant = oct;
		// Mirror the slope in odd octants
		if (oct == lmr_pkg::OCT_STEEP_UP || oct == lmr_pkg::OCT_SHALLOW_DOWN) begin
			job.slope = lmr_pkg::SLOPE_W'(lmr_pkg::DEG_PER_OCT - rem);
		end else begin
			job.slope = lmr_pkg::SLOPE_W'(rem);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/lmr_queue.sv =====
`default_nettype none

module lmr_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire lmr_pkg::job_t    push_job,
	input  wire logic             pop,
	output lmr_pkg::job_t         pop_job,
	output lmr_pkg::q_stat_t      q_stat
);

	lmr_pkg::job_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign q_stat.not_empty = (count_q != 2'd0);
	assign q_stat.full      = (count_q == 2'd2);
	assign pop_job          = rd_ptr_q ? entry_q[1] : entry_q[0];

	// Store the pushed job
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/lmr_back.sv =====
`default_nettype none

module lmr_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [lmr_pkg::COORD_W-1:0]   side,
	input  wire logic                          q_not_empty,
	input  wire lmr_pkg::job_t                 job,
	output logic                               pop,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [lmr_pkg::M_DATA_W-1:0]       m_tdata,   // [5:0] pixel_col, [11:6] pixel_row,
	                                                      // [23:12] pixel_index
	output logic                               m_tlast    // last_pixel
);

	localparam int CW = lmr_pkg::COORD_W;
	localparam int IW = lmr_pkg::INDEX_W;

	logic                               active_q;
	logic                               half_q;
	logic [CW-1:0]                      x_q;
	logic [CW-1:0]                      y_q;
	logic signed [lmr_pkg::ERR_W-1:0]   err_q;
	lmr_pkg::octant_t                   oct_q;
	logic [lmr_pkg::SLOPE_W-1:0]        slope_q;

	logic                               m_tvalid_q;
	logic [lmr_pkg::M_DATA_W-1:0]       m_tdata_q;
	logic                               m_tlast_q;

	logic [CW-1:0]                      h;
	logic [CW-1:0]                      hp_x, hm_x, hp_y, hm_y;
	logic [CW-1:0]                      col, row;
	logic [IW-1:0]                      index;
	logic                               advance;
	logic                               final_step;
	logic signed [lmr_pkg::ERR_W-1:0]   err_sum;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// Load a new job only when the stepper is idle
	assign pop        = !active_q && q_not_empty;
	assign advance    = active_q && (!m_tvalid_q || m_tready);
	assign h          = {1'b0, side[CW-1:1]};
	assign final_step = (x_q == h);
	assign err_sum    = err_q + $signed({1'b0, slope_q, 1'b0});

	// Place the current pixel of the mirrored pair
	always_comb begin
		hp_x = h + x_q;
		hm_x = h - x_q;
		hp_y = h + y_q;
		hm_y = h - y_q;
		unique case (oct_q)
			lmr_pkg::OCT_SHALLOW_UP: begin
				col = half_q ? hm_x : hp_x;
				row = half_q ? hm_y : hp_y;
			end
			lmr_pkg::OCT_STEEP_UP: begin
				col = half_q ? hm_y : hp_y;
				row = half_q ? hm_x : hp_x;
			end
			lmr_pkg::OCT_STEEP_DOWN: begin
				col = half_q ? hp_y : hm_y;
				row = half_q ? hm_x : hp_x;
			end
			lmr_pkg::OCT_SHALLOW_DOWN: begin
				col = half_q ? hm_x : hp_x;
				row = half_q ? hp_y : hm_y;
			end
			default: begin
				col = hp_x;
				row = hp_y;
			end
		endcase
		index = {{(IW-CW){1'b0}}, row} * {{(IW-CW){1'b0}}, side} + {{(IW-CW){1'b0}}, col};
	end

	// Hold the pixel until taken
	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= {index, row, col};
			m_tlast_q <= half_q && final_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Job parameters
	always_ff @(posedge clk) begin
		if (pop) begin
			oct_q   <= job.octant;
			slope_q <= job.slope;
		end
	end

	// Step the Bresenham walker, one pixel per cycle unless m_tready stalls the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			half_q   <= 1'b0;
			x_q      <= '0;
			y_q      <= '0;
			err_q    <= '0;
		end else if (pop) begin
			active_q <= 1'b1;
			half_q   <= 1'b0;
			x_q      <= '0;
			y_q      <= '0;
			err_q    <= lmr_pkg::ERR_START;
		end else if (advance) begin
			half_q <= !half_q;
			if (half_q) begin
				if (final_step) begin
					active_q <= 1'b0;
				end else begin
					x_q <= x_q + CW'(1);
					if (err_sum > 0) begin
						y_q   <= y_q + CW'(1);
						err_q <= err_sum - lmr_pkg::ERR_CORR;
					end else begin
						err_q <= err_sum;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/line_mask_rasterizer.sv =====
// The first pixel of a request reaches m_tdata through the job queue, the stepper
// registers and the output register. The stepper emits one pixel per cycle unless
// m_tready stalls it and reloads between requests; a 2-entry job queue lets angles
// arrive while a run is in progress.
// Reset (arst_n low, asynchronous): mask_side returns to 15, queue empties, stepper idles.
`default_nettype none

module line_mask_rasterizer #(
	parameter int MAX_SIDE = lmr_pkg::MAX_SIDE_DEFAULT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [lmr_pkg::S_DATA_W-1:0]      s_tdata,   // [7:0] angle_deg
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [lmr_pkg::M_DATA_W-1:0]           m_tdata,   // [5:0] pixel_col, [11:6] pixel_row,
	                                                          // [23:12] pixel_index
	output logic                                   m_tlast,   // last_pixel
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [lmr_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [lmr_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [lmr_pkg::APB_DATA_W-1:0]         prdata,
	output logic                                   pready
);

	localparam int CW = lmr_pkg::COORD_W;

	logic [CW-1:0]      mask_side_q;
	logic [CW-1:0]      side;
	logic               push;
	logic               pop;
	lmr_pkg::job_t      front_job;
	lmr_pkg::job_t      queue_job;
	lmr_pkg::q_stat_t   q_stat;
	logic               reg_hit;

	// Register file
	assign pready  = 1'b1;
	assign reg_hit = (paddr[lmr_pkg::APB_ADDR_W-1] == lmr_pkg::REG_MASK_SIDE);
	assign prdata  = reg_hit ? {{(lmr_pkg::APB_DATA_W-CW){1'b0}}, mask_side_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_side_q <= lmr_pkg::MASK_SIDE_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			mask_side_q <= pwdata[CW-1:0];
		end
	end

	// Clamp the side to the largest supported mask
	assign side = (mask_side_q > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : mask_side_q;

	lmr_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_stat.full),
		.push     (push),
		.job      (front_job)
	);

	lmr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (front_job),
		.pop      (pop),
		.pop_job  (queue_job),
		.q_stat   (q_stat)
	);

	lmr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.side        (side),
		.q_not_empty (q_stat.not_empty),
		.job         (queue_job),
		.pop         (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

`ifndef NO_ASSERTIONS
	logic [lmr_pkg::INDEX_W-1:0] idx_chk;
	assign idx_chk = {{(lmr_pkg::INDEX_W-CW){1'b0}}, m_tdata[2*CW-1:CW]}
		* {{(lmr_pkg::INDEX_W-CW){1'b0}}, side}
		+ {{(lmr_pkg::INDEX_W-CW){1'b0}}, m_tdata[CW-1:0]};

	a_index_matches: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[lmr_pkg::M_DATA_W-1:2*CW] == idx_chk))
		else $error("pixel index does not match row and column");

	a_pixel_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[CW-1:0] <= {side[CW-1:1], 1'b0})
			&& (m_tdata[2*CW-1:CW] <= {side[CW-1:1], 1'b0}))
		else $error("pixel outside the mask");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> q_stat.not_empty)
		else $error("accepted item missing from job queue");

	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> !$past(m_tvalid && !m_tready && m_tlast && !q_stat.not_empty))
		else $error("job popped without a queued entry");
`endif

endmodule

`default_nettype wire

// ===== tb/line_mask_rasterizer_tb.sv =====
`default_nettype none

module line_mask_rasterizer_tb;

	import lmr_pkg::*;

	localparam int MAX_SIDE   = MAX_SIDE_DEFAULT;
	localparam int IDLE_LIMIT = 2000;
	localparam int MAX_PIXELS = 64;
	localparam int GAP_MAX    = 18;
	// register index with no register behind it
	localparam int REG_UNUSED = 1;

	typedef enum int {
		PACE_FULL,
		PACE_RANDOM,
		PACE_SPARSE
	} pace_t;

	typedef struct {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [INDEX_W-1:0] index;
		logic               last;
	} pixel_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;    // [7:0] angle_deg
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;    // [5:0] pixel_col, [11:6] pixel_row, [23:12] pixel_index
	logic                  m_tlast;    // last_pixel
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	logic [ANGLE_W-1:0] angle_q[$];
	pixel_t             pixel_q[$];
	logic [COORD_W-1:0] side_cfg;
	pace_t              s_pace;
	pace_t              m_pace;
	int                 s_wait;
	int                 m_wait;
	bit                 s_took;
	int                 errors;
	int                 idle_cycles;
	pixel_t             want;
	// octant borders, both range ends, wrapped angles and one mid-octant angle
	int                 corner_angles[11] = '{0, 44, 45, 89, 90, 134, 135, 179, 180, 255, 22};

	line_mask_rasterizer #(
		.MAX_SIDE(MAX_SIDE)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report_mismatch(input string msg);
		errors++;
		$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	function automatic int draw_gap(input pace_t pace);
		case (pace)
			PACE_FULL:   return 0;
			PACE_RANDOM: return $urandom_range(0, GAP_MAX);
			default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(1, GAP_MAX) : 0;
		endcase
	endfunction

	task automatic push_pixel(input int col, input int row, input int side, input bit last);
		pixel_t p;
		p.col   = col[COORD_W-1:0];
		p.row   = row[COORD_W-1:0];
		p.index = INDEX_W'(row * side + col);
		p.last  = last;
		pixel_q.push_back(p);
	endtask

	// Walk the line for one angle and queue every pixel it sets
	task automatic rasterize_angle(input logic [ANGLE_W-1:0] angle_in);
		int      a;
		int      side;
		int      half;
		int      rem;
		int      slope;
		int      x;
		int      y;
		int      err;
		int      n;
		octant_t oct;
		a = angle_in;
		if (a >= int'(WRAP_DEG))
			a -= int'(WRAP_DEG);
		side = (side_cfg > MAX_SIDE) ? MAX_SIDE : side_cfg;
		half = side / 2;
		oct = octant_t'(a / int'(DEG_PER_OCT));
		rem = a % int'(DEG_PER_OCT);
		// odd octants measure the slope from the other axis
		slope = ((a / int'(DEG_PER_OCT)) % 2 == 1) ? int'(DEG_PER_OCT) - rem : rem;
		x = 0;
		y = 0;
		err = int'(ERR_START);
		n = 0;
		while (x <= half && n + 2 <= MAX_PIXELS) begin
			case (oct)
				OCT_SHALLOW_UP: begin
					push_pixel(half + x, half + y, side, 1'b0);
					push_pixel(half - x, half - y, side, x == half);
				end
				OCT_STEEP_UP: begin
					push_pixel(half + y, half + x, side, 1'b0);
					push_pixel(half - y, half - x, side, x == half);
				end
				OCT_STEEP_DOWN: begin
					push_pixel(half - y, half + x, side, 1'b0);
					push_pixel(half + y, half - x, side, x == half);
				end
				default: begin
					push_pixel(half + x, half - y, side, 1'b0);
					push_pixel(half - x, half + y, side, x == half);
				end
			endcase
			n += 2;
			x++;
			err += 2 * slope;
			if (err > 0) begin
				y++;
				err -= int'(ERR_CORR);
			end
		end
	endtask

	// Sample both streams: predict on accepted angles, check accepted pixels
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			rasterize_angle(s_tdata);
			void'(angle_q.pop_front());
			s_wait = draw_gap(s_pace);
			s_took = 1'b1;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (pixel_q.size() == 0) begin
				report_mismatch($sformatf("unexpected pixel col=%0d row=%0d idx=%0d last=%0b",
					m_tdata[5:0], m_tdata[11:6], m_tdata[23:12], m_tlast));
			end else begin
				want = pixel_q.pop_front();
				if (m_tdata[5:0] !== want.col)
					report_mismatch($sformatf("pixel_col %0d, want %0d", m_tdata[5:0], want.col));
				if (m_tdata[11:6] !== want.row)
					report_mismatch($sformatf("pixel_row %0d, want %0d", m_tdata[11:6], want.row));
				if (m_tdata[23:12] !== want.index)
					report_mismatch($sformatf("pixel_index %0d, want %0d", m_tdata[23:12],
						want.index));
				if (m_tlast !== want.last)
					report_mismatch($sformatf("last_pixel %0b, want %0b", m_tlast, want.last));
			end
			m_wait = draw_gap(m_pace);
		end
	end

	// Present angles from the pending queue, holding each until it is taken
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || s_took)) begin
			s_took = 1'b0;
			if (s_wait > 0) begin
				s_wait--;
				s_tvalid <= 1'b0;
			end else if (angle_q.size() > 0) begin
				s_tdata  <= angle_q[0];
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Stall the pixel stream for a randomly drawn gap after each accepted pixel
	always @(negedge clk) begin
		if (arst_n) begin
			if (m_wait > 0) begin
				m_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
			$display("** line_mask_rasterizer: FAILED **");
			$finish;
		end
	end

	// One register transfer; a read is checked against the expected register value
	task automatic apb_access(input bit wr, input int idx, input logic [APB_DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= APB_ADDR_W'(4 * idx);
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (wr && idx == int'(REG_MASK_SIDE))
			side_cfg = data[COORD_W-1:0];
		if (!wr && prdata !== APB_DATA_W'(side_cfg))
			report_mismatch($sformatf("mask_side reads %0d, want %0d", prdata, side_cfg));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Write the side with random upper bits, then read it back
	task automatic set_side(input int side);
		logic [APB_DATA_W-1:0] word;
		word = ($urandom() & ~APB_DATA_W'(6'h3f)) | APB_DATA_W'(side);
		apb_access(1'b1, int'(REG_MASK_SIDE), word);
		apb_access(1'b0, int'(REG_MASK_SIDE), '0);
	endtask

	// Wait for every pending angle and pixel, then let the pipeline settle
	task automatic drain();
		while (angle_q.size() > 0 || pixel_q.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		m_tready    = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		side_cfg    = MASK_SIDE_RESET;
		s_pace      = PACE_SPARSE;
		m_pace      = PACE_SPARSE;
		s_wait      = 0;
		m_wait      = 0;
		s_took      = 1'b0;
		errors      = 0;
		idle_cycles = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset side: octant borders, both range ends, wrapped angles and one mid-octant angle
		apb_access(1'b0, int'(REG_MASK_SIDE), '0);
		foreach (corner_angles[i])
			angle_q.push_back(ANGLE_W'(corner_angles[i]));
		drain();

		// A write to an unused index must leave the side alone
		apb_access(1'b1, REG_UNUSED, 32'hffff_ffff);
		apb_access(1'b0, int'(REG_MASK_SIDE), '0);

		// Zero side gives the origin twice
		set_side(0);
		angle_q.push_back(8'd0);
		angle_q.push_back(8'd100);
		drain();

		// Largest side, full 64-pixel runs
		set_side(63);
		angle_q.push_back(8'd0);
		angle_q.push_back(8'd45);
		angle_q.push_back(8'd179);
		drain();

		// Even sides reach the side itself; side 1 keeps every pixel at the origin
		set_side(62);
		angle_q.push_back(8'd30);
		angle_q.push_back(8'd120);
		drain();
		set_side(1);
		angle_q.push_back(8'd60);
		drain();
		set_side(2);
		angle_q.push_back(8'd150);
		drain();

		// Random phases, mostly small masks
		for (int ph = 0; ph < 10; ph++) begin
			if ($urandom_range(0, 9) < 7)
				set_side($urandom_range(0, 15));
			else
				set_side($urandom_range(0, 63));
			s_pace = pace_t'($urandom_range(0, 2));
			m_pace = pace_t'($urandom_range(0, 2));
			for (int k = 0; k < 32; k++) begin
				if ($urandom_range(0, 9) == 0)
					angle_q.push_back(ANGLE_W'($urandom_range(180, 255)));
				else
					angle_q.push_back(ANGLE_W'($urandom_range(0, 179)));
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("** line_mask_rasterizer: PASSED **");
		else
			$display("** line_mask_rasterizer: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
